[rtl/tgc_pkg.sv]
`default_nettype none

package tgc_pkg;

  localparam int unsigned DimW   = 16;
  localparam int unsigned TileW  = 13;
  localparam int unsigned ProdW  = DimW + TileW;
  localparam int unsigned RootW  = 15;
  localparam int unsigned AreaW  = 2 * TileW;
  localparam int unsigned CrossW = AreaW + DimW;
  localparam int unsigned CntW   = 5;

  typedef struct packed {
    logic [DimW-1:0]  image_height;
    logic [DimW-1:0]  image_width;
    logic [TileW-1:0] tile_count;
  } tgc_in_t;

  typedef struct packed {
    logic [TileW-1:0] grid_rows;
    logic [TileW-1:0] grid_columns;
  } tgc_out_t;

  // A narrow request divides a tile-sized value and runs only TileW steps.
  typedef struct packed {
    logic             start;
    logic             narrow;
    logic [ProdW-1:0] dividend;
    logic [DimW-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [ProdW-1:0] quotient;
    logic [DimW-1:0]  remainder;
  } div_rsp_t;

  typedef struct packed {
    logic             start;
    logic [ProdW-1:0] value;
  } sqrt_req_t;

  typedef struct packed {
    logic             done;
    logic [RootW-1:0] root;
  } sqrt_rsp_t;

endpackage

`default_nettype wire

[rtl/tile_grid_chooser_top.sv]
// The sequencer takes its shortest path when lo is zero or hi exceeds the tile count; otherwise
// each divisor tried while lo steps down and hi steps up adds a divide; the bit-serial
// divider, one quotient bit a cycle, sets the pace.
// Busy stays high from acceptance until the result strobe, and the next item is taken
// in the cycle after the strobe.
// The result stands for exactly one cycle and the receiver cannot stall it.
// Reset (rst_ni low, asynchronous) returns the sequencer to idle with no result.
`default_nettype none

module tile_grid_chooser_top
  import tgc_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    start,
  output logic         busy,
  input  wire tgc_in_t item_i,
  output logic         result_valid_o,
  output tgc_out_t     result_o
);

  localparam logic [4:0] StIdle    = 5'd0;
  localparam logic [4:0] StMul     = 5'd1;
  localparam logic [4:0] StDqGo    = 5'd2;
  localparam logic [4:0] StDqWait  = 5'd3;
  localparam logic [4:0] StSqGo    = 5'd4;
  localparam logic [4:0] StSqWait  = 5'd5;
  localparam logic [4:0] StCheck   = 5'd6;
  localparam logic [4:0] StLoGo    = 5'd7;
  localparam logic [4:0] StLoWait  = 5'd8;
  localparam logic [4:0] StHiGo    = 5'd9;
  localparam logic [4:0] StHiWait  = 5'd10;
  localparam logic [4:0] StAreaMul = 5'd11;
  localparam logic [4:0] StCrossMul = 5'd12;
  localparam logic [4:0] StCmp     = 5'd13;
  localparam logic [4:0] StColGo   = 5'd14;
  localparam logic [4:0] StColWait = 5'd15;
  localparam logic [4:0] StDone    = 5'd16;

  logic [4:0]        state_q, state_d;
  logic [DimW-1:0]   h_q, h_d;
  logic [DimW-1:0]   w_q, w_d;
  logic [TileW-1:0]  t_q, t_d;
  logic [ProdW-1:0]  prod_q, prod_d;
  logic [RootW-1:0]  lo_q, lo_d;
  logic [RootW-1:0]  hi_q, hi_d;
  logic [AreaW-1:0]  area_q, area_d;
  logic [CrossW-1:0] cross_q, cross_d;
  logic [TileW-1:0]  rows_q, rows_d;
  logic [TileW-1:0]  cols_q, cols_d;

  div_req_t  div_req;
  div_rsp_t  div_rsp;
  sqrt_req_t sqrt_req;
  sqrt_rsp_t sqrt_rsp;

  tgc_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  tgc_isqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (sqrt_req),
    .rsp_o  (sqrt_rsp)
  );

  // The one divider serves the scaled area, both divisor searches and the column count.
  always_comb begin
    div_req.start    = (state_q == StDqGo) || (state_q == StLoGo) ||
                       (state_q == StHiGo) || (state_q == StColGo);
    div_req.narrow   = (state_q != StDqGo);
    div_req.dividend = prod_q;
    div_req.divisor  = w_q;
    unique case (state_q)
      StDqGo: begin
        div_req.dividend = prod_q;
        div_req.divisor  = w_q;
      end
      StLoGo: begin
        div_req.dividend = ProdW'(t_q);
        div_req.divisor  = DimW'(lo_q);
      end
      StHiGo: begin
        div_req.dividend = ProdW'(t_q);
        div_req.divisor  = DimW'(hi_q);
      end
      StColGo: begin
        div_req.dividend = ProdW'(t_q);
        div_req.divisor  = DimW'(rows_q);
      end
      default: begin
        div_req.dividend = prod_q;
        div_req.divisor  = w_q;
      end
    endcase
    sqrt_req.start = (state_q == StSqGo);
    sqrt_req.value = div_rsp.quotient;
  end

  always_comb begin
    state_d = state_q;
    h_d     = h_q;
    w_d     = w_q;
    t_d     = t_q;
    prod_d  = prod_q;
    lo_d    = lo_q;
    hi_d    = hi_q;
    area_d  = area_q;
    cross_d = cross_q;
    rows_d  = rows_q;
    cols_d  = cols_q;
    unique case (state_q)
      StIdle: begin
        if (start) begin
          h_d     = item_i.image_height;
          w_d     = (item_i.image_width == '0) ? DimW'(1) : item_i.image_width;
          t_d     = item_i.tile_count;
          state_d = StMul;
        end
      end
      StMul: begin
        prod_d  = ProdW'(t_q) * ProdW'(h_q);
        state_d = StDqGo;
      end
      StDqGo:   state_d = StDqWait;
      StDqWait: begin
        if (div_rsp.done) begin
          state_d = StSqGo;
        end
      end
      StSqGo:   state_d = StSqWait;
      StSqWait: begin
        if (sqrt_rsp.done) begin
          lo_d    = sqrt_rsp.root;
          state_d = StCheck;
        end
      end
      StCheck: begin
        if (lo_q == '0) begin
          rows_d  = TileW'(1);
          cols_d  = t_q;
          state_d = StDone;
        end else if (({1'b0, lo_q} + 16'd1) > 16'(t_q)) begin
          rows_d  = t_q;
          cols_d  = TileW'(1);
          state_d = StDone;
        end else begin
          hi_d    = lo_q + RootW'(1);
          state_d = StLoGo;
        end
      end
      StLoGo:   state_d = StLoWait;
      StLoWait: begin
        if (div_rsp.done) begin
          if (div_rsp.remainder == '0) begin
            state_d = StHiGo;
          end else begin
            lo_d    = lo_q - RootW'(1);
            state_d = StLoGo;
          end
        end
      end
      StHiGo:   state_d = StHiWait;
      StHiWait: begin
        if (div_rsp.done) begin
          if (div_rsp.remainder == '0) begin
            state_d = StAreaMul;
          end else begin
            hi_d    = hi_q + RootW'(1);
            state_d = StHiGo;
          end
        end
      end
      StAreaMul: begin
        area_d  = AreaW'(hi_q[TileW-1:0]) * AreaW'(lo_q[TileW-1:0]);
        state_d = StCrossMul;
      end
      StCrossMul: begin
        cross_d = CrossW'(area_q) * CrossW'(w_q);
        state_d = StCmp;
      end
      StCmp: begin
        rows_d  = (cross_q > CrossW'(prod_q)) ? lo_q[TileW-1:0] : hi_q[TileW-1:0];
        state_d = StColGo;
      end
      StColGo:   state_d = StColWait;
      StColWait: begin
        if (div_rsp.done) begin
          cols_d  = div_rsp.quotient[TileW-1:0];
          state_d = StDone;
        end
      end
      StDone:  state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    h_q     <= h_d;
    w_q     <= w_d;
    t_q     <= t_d;
    prod_q  <= prod_d;
    lo_q    <= lo_d;
    hi_q    <= hi_d;
    area_q  <= area_d;
    cross_q <= cross_d;
    rows_q  <= rows_d;
    cols_q  <= cols_d;
  end

  assign busy                  = (state_q != StIdle);
  assign result_valid_o        = (state_q == StDone);
  assign result_o.grid_rows    = rows_q;
  assign result_o.grid_columns = cols_q;

endmodule

`default_nettype wire

[rtl/tgc_divider.sv]
`default_nettype none

module tgc_divider
  import tgc_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire div_req_t req_i,
  output div_rsp_t      rsp_o
);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [ProdW-1:0] quo_q, quo_d;
  logic [DimW-1:0]  rem_q, rem_d;
  logic [DimW-1:0]  dvs_q, dvs_d;
  logic [DimW:0]    trial;
  logic             fits;

  // One restoring step per cycle: shift in the next dividend bit and try the subtract.
  // The divisor is held from the start cycle, so the requester may move on.
  always_comb begin
    trial  = {rem_q, quo_q[ProdW-1]} - {1'b0, dvs_q};
    fits   = ({rem_q, quo_q[ProdW-1]} >= {1'b0, dvs_q});
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (busy_q) begin
      rem_d = fits ? trial[DimW-1:0] : {rem_q[DimW-2:0], quo_q[ProdW-1]};
      quo_d = {quo_q[ProdW-2:0], fits};
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end else if (req_i.start) begin
      busy_d = 1'b1;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
      if (req_i.narrow) begin
        quo_d = {req_i.dividend[TileW-1:0], DimW'(0)};
        cnt_d = CntW'(TileW);
      end else begin
        quo_d = req_i.dividend;
        cnt_d = CntW'(ProdW);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = quo_q;
  assign rsp_o.remainder = rem_q;

endmodule

`default_nettype wire

[rtl/tgc_isqrt.sv]
`default_nettype none

module tgc_isqrt
  import tgc_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire sqrt_req_t req_i,
  output sqrt_rsp_t      rsp_o
);

  localparam int unsigned ResW = ProdW + 1;

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [ProdW-1:0] v_q, v_d;
  logic [ResW-1:0]  res_q, res_d;
  logic [ProdW-1:0] bit_q, bit_d;
  logic [ResW-1:0]  sum;

  // Digit-by-digit root: one bit pair of the radicand is settled per cycle.
  always_comb begin
    sum    = res_q + {1'b0, bit_q};
    busy_d = busy_q;
    done_d = 1'b0;
    v_d    = v_q;
    res_d  = res_q;
    bit_d  = bit_q;
    if (busy_q) begin
      if ({1'b0, v_q} >= sum) begin
        v_d   = v_q - sum[ProdW-1:0];
        res_d = (res_q >> 1) + {1'b0, bit_q};
      end else begin
        res_d = res_q >> 1;
      end
      bit_d = bit_q >> 2;
      if (bit_q[0]) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end else if (req_i.start) begin
      busy_d = 1'b1;
      v_d    = req_i.value;
      res_d  = '0;
      bit_d  = {1'b1, {(ProdW-1){1'b0}}};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q   <= v_d;
    res_q <= res_d;
    bit_q <= bit_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.root = res_q[RootW-1:0];

endmodule

`default_nettype wire

[sim/tb_tile_grid_chooser_top.sv]
`default_nettype none

module tb_tile_grid_chooser_top;
  import tgc_pkg::*;

  localparam int unsigned ItemCount  = 580;
  // The limit is sized for the slowest item (prime tile count, hi walking all the way
  // up) and leaves a wide margin over it.
  localparam int unsigned WatchLimit = 600000;
  localparam int unsigned DrainCycles = 100;

  class grid_scoreboard;
    tgc_out_t    pending_grids[$];
    int unsigned mismatch_cnt;

    function new();
      mismatch_cnt = 0;
    endfunction

    function tgc_out_t predict_grid(tgc_in_t req);
      logic [63:0] h, w, t, quot, root, cand, lo, hi, rows, cols;
      tgc_out_t    grid;
      h = 64'(req.image_height);
      w = 64'(req.image_width);
      t = 64'(req.tile_count);
      if (w == 0) begin
        w = 1;
      end
      quot = (t * h) / w;
      root = 0;
      for (int b = 15; b >= 0; b--) begin
        cand = root | (64'd1 << b);
        if (cand * cand <= quot) begin
          root = cand;
        end
      end
      lo = root;
      hi = root + 1;
      if (lo < 1) begin
        rows = 1;
        cols = t;
      end else if (hi > t) begin
        rows = t;
        cols = 1;
      end else begin
        while (t % lo != 0) lo--;
        while (t % hi != 0) hi++;
        rows = (hi * lo * w > t * h) ? lo : hi;
        cols = t / rows;
      end
      grid.grid_rows    = rows[TileW-1:0];
      grid.grid_columns = cols[TileW-1:0];
      return grid;
    endfunction

    function void note_request(tgc_in_t req);
      pending_grids.insert(pending_grids.size(), predict_grid(req));
    endfunction

    function void check_grid(tgc_out_t got);
      tgc_out_t want;
      if (pending_grids.size() == 0) begin
        $error("result beat with no request pending: rows %0d columns %0d",
               got.grid_rows, got.grid_columns);
        mismatch_cnt++;
        return;
      end
      want = pending_grids.pop_front();
      if (got.grid_rows !== want.grid_rows) begin
        $error("grid_rows: expected %0d, actual %0d", want.grid_rows, got.grid_rows);
        mismatch_cnt++;
      end
      if (got.grid_columns !== want.grid_columns) begin
        $error("grid_columns: expected %0d, actual %0d",
               want.grid_columns, got.grid_columns);
        mismatch_cnt++;
      end
    endfunction
  endclass

  logic     clk_i;
  logic     rst_ni;
  logic     start;
  logic     busy;
  tgc_in_t  item_i;
  logic     result_valid_o;
  tgc_out_t result_o;

  grid_scoreboard sb = new();
  int unsigned    stall_cycles = 0;

  tile_grid_chooser_top i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .item_i        (item_i),
    .result_valid_o(result_valid_o),
    .result_o      (result_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      sb.check_grid(result_o);
    end
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || result_valid_o) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WatchLimit) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // A gap of zero keeps start high, so the next beat goes in on the first
  // edge at which busy is low. Otherwise start drops and the gap is counted
  // from the moment the block is seen idle.
  task automatic send_item(tgc_in_t req, int unsigned gap);
    @(negedge clk_i);
    if (gap != 0) begin
      start <= 1'b0;
      while (busy) @(negedge clk_i);
      repeat (gap - 1) @(negedge clk_i);
    end
    start  <= 1'b1;
    item_i <= req;
    do @(posedge clk_i); while (busy);
    sb.note_request(req);
  endtask

  initial begin
    tgc_in_t     req;
    int unsigned pick;
    int unsigned num, den;
    logic [31:0] scaled;

    rst_ni = 1'b0;
    start  = 1'b0;
    item_i = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed corners: field extremes, zero height, zero width, zero tiles,
    // the single-row and single-column exits and the divisor searches.
    send_item({16'd1,     16'd1,     13'd1},    $urandom_range(0, 19));
    send_item({16'd65535, 16'd65535, 13'd4096}, $urandom_range(0, 19));
    send_item({16'd65535, 16'd1,     13'd8191}, $urandom_range(0, 19));
    send_item({16'd1,     16'd65535, 13'd8191}, $urandom_range(0, 19));
    send_item({16'd1,     16'd65535, 13'd4096}, $urandom_range(0, 19));
    send_item({16'd0,     16'd100,   13'd12},   $urandom_range(0, 19));
    send_item({16'd100,   16'd0,     13'd12},   $urandom_range(0, 19));
    send_item({16'd10,    16'd0,     13'd64},   $urandom_range(0, 19));
    send_item({16'd100,   16'd100,   13'd0},    $urandom_range(0, 19));
    send_item({16'd0,     16'd0,     13'd0},    $urandom_range(0, 19));
    send_item({16'd1080,  16'd1920,  13'd12},   $urandom_range(0, 19));
    send_item({16'd1920,  16'd1080,  13'd12},   $urandom_range(0, 19));
    send_item({16'd480,   16'd640,   13'd16},   $urandom_range(0, 19));
    send_item({16'd500,   16'd500,   13'd97},   $urandom_range(0, 19));
    send_item({16'd777,   16'd777,   13'd2},    $urandom_range(0, 19));
    send_item({16'd4096,  16'd4096,  13'd4096}, $urandom_range(0, 19));
    send_item({16'd3000,  16'd3000,  13'd8190}, 0);
    send_item({16'd65535, 16'd2,     13'd30},   0);
    send_item({16'd2,     16'd65535, 13'd30},   $urandom_range(0, 19));
    send_item({16'd1234,  16'd4321,  13'd360},  $urandom_range(0, 19));

    for (int n = 0; n < ItemCount; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 1) begin
        req.tile_count = 13'($urandom_range(0, 8191));
      end else if (pick < 10) begin
        req.tile_count = 13'($urandom_range(1, 1023));
      end else begin
        req.tile_count = 13'($urandom_range(1, 127));
      end
      req.image_height = 16'($urandom);
      if ($urandom_range(0, 1) == 0) begin
        req.image_width = 16'($urandom);
      end else begin
        // Similar aspect ratios keep lo and hi away from the early exits.
        num    = $urandom_range(1, 16);
        den    = $urandom_range(1, 16);
        scaled = (32'(req.image_height) * num) / den;
        req.image_width = (scaled > 32'd65535) ? 16'd65535 : 16'(scaled);
      end
      pick = $urandom_range(0, 99);
      if (pick == 0) begin
        req.image_height = '0;
      end else if (pick == 1) begin
        req.image_width = '0;
      end else if (pick == 2) begin
        req.tile_count = '0;
      end
      send_item(req, ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19));
    end

    @(negedge clk_i);
    start <= 1'b0;
    while (sb.pending_grids.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.mismatch_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

[sim.f]
rtl/tgc_pkg.sv
rtl/tgc_divider.sv
rtl/tgc_isqrt.sv
rtl/tile_grid_chooser_top.sv
sim/tb_tile_grid_chooser_top.sv
